[sv/bvm_pkg.sv]
// Package for the byte register machine core.
// Request/response payload types, the execute result struct and opcode codes.
// No dependencies.
`default_nettype none

package bvm_pkg;

    // Request kinds
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_RUN  = 1'b1;

    // Opcodes
    localparam logic [7:0] OP_INC  = 8'd1;
    localparam logic [7:0] OP_DEC  = 8'd2;
    localparam logic [7:0] OP_MOV  = 8'd3;
    localparam logic [7:0] OP_MOVI = 8'd4;
    localparam logic [7:0] OP_LSL  = 8'd5;
    localparam logic [7:0] OP_LSR  = 8'd6;
    localparam logic [7:0] OP_JMP  = 8'd7;
    localparam logic [7:0] OP_JZ   = 8'd8;
    localparam logic [7:0] OP_JNZ  = 8'd9;
    localparam logic [7:0] OP_JFE  = 8'd10;
    localparam logic [7:0] OP_RET  = 8'd11;
    localparam logic [7:0] OP_ADD  = 8'd12;
    localparam logic [7:0] OP_SUB  = 8'd13;
    localparam logic [7:0] OP_XOR  = 8'd14;
    localparam logic [7:0] OP_OR   = 8'd15;
    localparam logic [7:0] OP_IN   = 8'd16;
    localparam logic [7:0] OP_OUT  = 8'd17;

    typedef struct packed {
        logic       mode;
        logic [7:0] addr;
        logic [7:0] data;
        logic       in_eof;
    } bvm_req_t;

    typedef struct packed {
        logic       out_valid;
        logic [7:0] out_byte;
        logic       in_taken;
        logic       halted;
        logic [7:0] prog_counter;
    } bvm_rsp_t;

    // What one instruction does to the machine state
    typedef struct packed {
        logic       wr_en;      // write a register
        logic       wr_r0;      // target is R0 instead of Rx
        logic [7:0] wr_data;
        logic       zero;       // zero flag after the instruction
        logic       eof;        // end-of-input flag after the instruction
        logic [7:0] last;       // last input byte after the instruction
        logic       halt;       // RET executed
        logic       jump;       // taken jump
        logic       out_valid;
        logic [7:0] out_byte;
        logic       in_taken;
    } bvm_exec_t;

endpackage

`default_nettype wire

[sv/bvm_exec.sv]
// Instruction execute unit of the byte register machine core.
// Decodes one opcode and computes register write, flags, jump, halt and I/O.
// Depends on bvm_pkg.
`default_nettype none

module bvm_exec (
    input  wire logic [7:0]        op,
    input  wire logic [7:0]        opd,
    input  wire logic [7:0]        x,
    input  wire logic [7:0]        y,
    input  wire logic              zero_flag,
    input  wire logic              end_flag,
    input  wire logic [7:0]        last_byte,
    input  wire logic [7:0]        data,
    input  wire logic              in_eof,
    output bvm_pkg::bvm_exec_t     res
);

    logic [7:0] sum_xy;
    logic [7:0] dif_xy;
    logic [7:0] inc_x;
    logic [7:0] dec_x;

    assign sum_xy = 8'(x + y);
    assign dif_xy = 8'(x - y);
    assign inc_x  = 8'(x + 8'd1);
    assign dec_x  = 8'(x - 8'd1);

    // Decode; flags hold unless the instruction touches them
    always_comb
    begin
        res           = '0;
        res.zero      = zero_flag;
        res.eof       = end_flag;
        res.last      = last_byte;
        case (op)
            bvm_pkg::OP_INC:
            begin
                res.wr_en   = 1'b1;
                res.wr_data = inc_x;
                res.zero    = 1'b0;
            end
            bvm_pkg::OP_DEC:
            begin
                res.wr_en   = 1'b1;
                res.wr_data = dec_x;
                res.zero    = (dec_x == 8'd0);
            end
            bvm_pkg::OP_MOV:
            begin
                res.wr_en   = 1'b1;
                res.wr_data = y;
                res.zero    = (y == 8'd0);
            end
            bvm_pkg::OP_MOVI:
            begin
                res.wr_en   = 1'b1;
                res.wr_r0   = 1'b1;
                res.wr_data = opd;
                res.zero    = (opd == 8'd0);
            end
            bvm_pkg::OP_LSL:
            begin
                res.wr_en   = 1'b1;
                res.wr_data = {x[6:0], 1'b0};
                res.zero    = (x[6:0] == 7'd0);
            end
            bvm_pkg::OP_LSR:
            begin
                res.wr_en   = 1'b1;
                res.wr_data = {1'b0, x[7:1]};
                res.zero    = (x[7:1] == 7'd0);
            end
            bvm_pkg::OP_JMP: res.jump = 1'b1;
            bvm_pkg::OP_JZ:  res.jump = zero_flag;
            bvm_pkg::OP_JNZ: res.jump = !zero_flag;
            bvm_pkg::OP_JFE: res.jump = end_flag;
            bvm_pkg::OP_RET: res.halt = 1'b1;
            bvm_pkg::OP_ADD:
            begin
                res.wr_en   = 1'b1;
                res.wr_data = sum_xy;
                res.zero    = (sum_xy == 8'd0);
            end
            bvm_pkg::OP_SUB:
            begin
                // saturates at zero
                res.wr_en = 1'b1;
                if (x <= y)
                begin
                    res.wr_data = 8'd0;
                    res.zero    = 1'b1;
                end
                else
                begin
                    res.wr_data = dif_xy;
                    res.zero    = 1'b0;
                end
            end
            bvm_pkg::OP_XOR:
            begin
                res.wr_en   = 1'b1;
                res.wr_data = x ^ y;
                res.zero    = ((x ^ y) == 8'd0);
            end
            bvm_pkg::OP_OR:
            begin
                res.wr_en   = 1'b1;
                res.wr_data = x | y;
                res.zero    = ((x | y) == 8'd0);
            end
            bvm_pkg::OP_IN:
            begin
                // at end of input Rx gets the last byte seen
                res.wr_en = 1'b1;
                res.zero  = 1'b0;
                if (in_eof)
                begin
                    res.eof     = 1'b1;
                    res.wr_data = last_byte;
                end
                else
                begin
                    res.eof      = 1'b0;
                    res.last     = data;
                    res.wr_data  = data;
                    res.in_taken = 1'b1;
                end
            end
            bvm_pkg::OP_OUT:
            begin
                res.out_valid = 1'b1;
                res.out_byte  = x;
                res.zero      = 1'b0;
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

[sv/byte_register_vm_core_unit.sv]
// Top level of the byte register machine core: program store, register file,
// sequencing and the response register. Depends on bvm_pkg and bvm_exec.
//
//   channel | valid     | stall     | payload | direction
//   --------+-----------+-----------+---------+----------
//   request | req_valid | req_stall | req     | in
//   response| rsp_valid | rsp_stall | rsp     | out
//
// Each request passes through FETCH, which holds the program store read data
// (opcode and operand on two read ports), and EXEC, which holds the register
// file read data and executes. A new request is taken only while idle or as
// the previous one leaves execute. Reset clears control state and per-entry
// valid bits of both memories; entries never written read as zero. A stalled
// response holds the block in execute until the response register frees.
`default_nettype none

module byte_register_vm_core_unit #(
    parameter int PROG_DEPTH = 256,
    parameter int REG_COUNT  = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_stall,
    input  wire bvm_pkg::bvm_req_t  req,
    output logic                    rsp_valid,
    input  wire logic               rsp_stall,
    output bvm_pkg::bvm_rsp_t       rsp
);

    localparam int PA = $clog2(PROG_DEPTH);
    localparam int RA = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
    localparam logic [11:0] PD = 12'(PROG_DEPTH);
    localparam logic [7:0]  RC = 8'(REG_COUNT);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_FETCH = 2'd1;
    localparam logic [1:0] ST_EXEC  = 2'd2;

    // Byte address mod PROG_DEPTH by restoring compare-subtract
    function automatic logic [PA-1:0] prog_index(input logic [7:0] a);
        logic [11:0] v;
        v = {4'd0, a};
        for (int k = 3; k >= 0; k--)
        begin
            if (v >= (PD << k))
                v = 12'(v - (PD << k));
        end
        return v[PA-1:0];
    endfunction

    // Register number mod REG_COUNT
    function automatic logic [RA-1:0] reg_index(input logic [3:0] n);
        logic [7:0] v;
        v = {4'd0, n};
        for (int k = 2; k >= 0; k--)
        begin
            if (v >= (RC << k))
                v = 8'(v - (RC << k));
        end
        return v[RA-1:0];
    endfunction

    logic [1:0]         state_reg;
    logic [1:0]         state_next;
    bvm_pkg::bvm_req_t  item_reg;

    logic [7:0]         pc_reg;
    logic [7:0]         pc_next;
    logic               zero_reg;
    logic               eof_reg;
    logic               halt_reg;
    logic [7:0]         last_reg;

    logic [7:0]             prog_mem [PROG_DEPTH];
    logic [PROG_DEPTH-1:0]  prog_valid_reg;
    logic [7:0]             op_rd_reg;
    logic [7:0]             opd_rd_reg;
    logic                   op_ok_reg;
    logic                   opd_ok_reg;

    logic [7:0]             regs_mem [REG_COUNT];
    logic [REG_COUNT-1:0]   regs_valid_reg;
    logic [7:0]             x_rd_reg;
    logic [7:0]             y_rd_reg;
    logic                   x_ok_reg;
    logic                   y_ok_reg;

    logic                   rsp_valid_reg;
    bvm_pkg::bvm_rsp_t      rsp_reg;
    bvm_pkg::bvm_rsp_t      rsp_next;

    logic               accept;
    logic               out_free;
    logic               exec_done;
    logic               run_live;
    logic               reg_wr;
    logic [7:0]         pc_src;
    logic [7:0]         pc_src1;
    logic [PA-1:0]      fetch0;
    logic [PA-1:0]      fetch1;
    logic [PA-1:0]      load_idx;
    logic [7:0]         op;
    logic [7:0]         opd;
    logic [7:0]         x;
    logic [7:0]         y;
    logic [RA-1:0]      rx;
    logic [RA-1:0]      ry;
    logic [RA-1:0]      wr_idx;
    bvm_pkg::bvm_exec_t exec_res;

    // Handshake and sequencing
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign exec_done = (state_reg == ST_EXEC) && out_free;
    assign req_stall = !((state_reg == ST_IDLE) || exec_done);
    assign accept    = req_valid && !req_stall;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (accept) state_next = ST_FETCH;
            ST_FETCH: state_next = ST_EXEC;
            ST_EXEC:
            begin
                if (accept)
                    state_next = ST_FETCH;
                else if (exec_done)
                    state_next = ST_IDLE;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // Fetch address: pc forwarded from the instruction finishing this cycle
    assign pc_src   = (state_reg == ST_EXEC) ? pc_next : pc_reg;
    assign pc_src1  = 8'(pc_src + 8'd1);
    assign fetch0   = prog_index(pc_src);
    assign fetch1   = prog_index(pc_src1);
    assign load_idx = prog_index(req.addr);

    // Program store: one write port, two read ports, registered read data
    always_ff @(posedge clk)
    begin
        if (accept && (req.mode == bvm_pkg::MODE_LOAD))
            prog_mem[load_idx] <= req.data;
        if (accept)
        begin
            op_rd_reg  <= prog_mem[fetch0];
            opd_rd_reg <= prog_mem[fetch1];
            op_ok_reg  <= prog_valid_reg[fetch0];
            opd_ok_reg <= prog_valid_reg[fetch1];
        end
    end

    assign op  = op_ok_reg  ? op_rd_reg  : 8'd0;
    assign opd = opd_ok_reg ? opd_rd_reg : 8'd0;
    assign rx  = reg_index(opd[3:0]);
    assign ry  = reg_index(opd[7:4]);

    // Register file: read Rx and Ry after fetch, write back on execute
    assign run_live = (item_reg.mode == bvm_pkg::MODE_RUN) && !halt_reg;
    assign reg_wr   = exec_done && run_live && exec_res.wr_en;
    assign wr_idx   = exec_res.wr_r0 ? '0 : rx;

    always_ff @(posedge clk)
    begin
        if (reg_wr)
            regs_mem[wr_idx] <= exec_res.wr_data;
        if (state_reg == ST_FETCH)
        begin
            x_rd_reg <= regs_mem[rx];
            y_rd_reg <= regs_mem[ry];
            x_ok_reg <= regs_valid_reg[rx];
            y_ok_reg <= regs_valid_reg[ry];
        end
    end

    assign x = x_ok_reg ? x_rd_reg : 8'd0;
    assign y = y_ok_reg ? y_rd_reg : 8'd0;

    bvm_exec u_exec (
        .op        (op),
        .opd       (opd),
        .x         (x),
        .y         (y),
        .zero_flag (zero_reg),
        .end_flag  (eof_reg),
        .last_byte (last_reg),
        .data      (item_reg.data),
        .in_eof    (item_reg.in_eof),
        .res       (exec_res)
    );

    // Next pc and response
    always_comb
    begin
        pc_next = pc_reg;
        if (run_live && !exec_res.halt)
        begin
            if (exec_res.jump)
                pc_next = 8'(pc_reg + opd);
            else
                pc_next = 8'(pc_reg + 8'd2);
        end
        rsp_next              = '0;
        rsp_next.halted       = halt_reg || (run_live && exec_res.halt);
        rsp_next.prog_counter = pc_next;
        if (run_live)
        begin
            rsp_next.out_valid = exec_res.out_valid;
            rsp_next.out_byte  = exec_res.out_byte;
            rsp_next.in_taken  = exec_res.in_taken;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= req;
        if (exec_done)
            rsp_reg <= rsp_next;
    end

    // Control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pc_reg         <= 8'd0;
            zero_reg       <= 1'b0;
            eof_reg        <= 1'b0;
            halt_reg       <= 1'b0;
            last_reg       <= 8'd0;
            prog_valid_reg <= '0;
            regs_valid_reg <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept && (req.mode == bvm_pkg::MODE_LOAD))
                prog_valid_reg[load_idx] <= 1'b1;
            if (reg_wr)
                regs_valid_reg[wr_idx] <= 1'b1;
            if (exec_done && run_live)
            begin
                pc_reg   <= pc_next;
                zero_reg <= exec_res.zero;
                eof_reg  <= exec_res.eof;
                last_reg <= exec_res.last;
                halt_reg <= exec_res.halt;
            end
            if (exec_done)
                rsp_valid_reg <= 1'b1;
            else if (!rsp_stall)
                rsp_valid_reg <= 1'b0;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

[tb/sv/bvm_core_checker.sv]
// Scoreboard for the byte register machine core: watches both channels,
// predicts each response from a local copy of the machine state and compares.
// Depends on bvm_pkg.
`default_nettype none

module bvm_core_checker #(
    parameter int PROG_DEPTH = 256,
    parameter int REG_COUNT  = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    input  wire logic              req_stall,
    input  wire bvm_pkg::bvm_req_t req,
    input  wire logic              rsp_valid,
    input  wire logic              rsp_stall,
    input  wire bvm_pkg::bvm_rsp_t rsp,
    output int                     fail_count,
    output int                     pending,
    output logic [7:0]             model_pc
);

    // Shadow machine state
    logic [7:0] prog_mem [PROG_DEPTH];
    logic [7:0] regs [REG_COUNT];
    logic [7:0] pc_q;
    logic       zf;
    logic       eof_f;
    logic       halt_f;
    logic [7:0] last_in;

    // Responses predicted but not yet seen, oldest first
    bvm_pkg::bvm_rsp_t   expected_rsp_q[$];
    bvm_pkg::bvm_rsp_t   oldest;

    assign model_pc = pc_q;

    // Apply one request to the shadow state and return the response it causes
    function automatic bvm_pkg::bvm_rsp_t execute_request(input bvm_pkg::bvm_req_t r);
        bvm_pkg::bvm_rsp_t res;
        logic [7:0]  op;
        logic [7:0]  opd;
        logic [7:0]  x;
        logic [7:0]  y;
        logic [7:0]  v;
        int unsigned rx;
        int unsigned ry;
        logic        jump;
        res  = '0;
        jump = 1'b0;
        if (r.mode == bvm_pkg::MODE_LOAD) begin
            prog_mem[int'(r.addr) % PROG_DEPTH] = r.data;
        end
        else if (!halt_f) begin
            op  = prog_mem[int'(pc_q) % PROG_DEPTH];
            opd = prog_mem[(int'(pc_q) + 1) % PROG_DEPTH];
            rx  = int'(opd[3:0]) % REG_COUNT;
            ry  = int'(opd[7:4]) % REG_COUNT;
            x   = regs[rx];
            y   = regs[ry];
            case (op)
                bvm_pkg::OP_INC:
                begin
                    regs[rx] = x + 8'd1;
                    zf = 1'b0;
                end
                bvm_pkg::OP_DEC:
                begin
                    v = x - 8'd1;
                    regs[rx] = v;
                    zf = (v == 8'd0);
                end
                bvm_pkg::OP_MOV:
                begin
                    regs[rx] = y;
                    zf = (y == 8'd0);
                end
                bvm_pkg::OP_MOVI:
                begin
                    regs[0] = opd;
                    zf = (opd == 8'd0);
                end
                bvm_pkg::OP_LSL:
                begin
                    v = {x[6:0], 1'b0};
                    regs[rx] = v;
                    zf = (v == 8'd0);
                end
                bvm_pkg::OP_LSR:
                begin
                    v = {1'b0, x[7:1]};
                    regs[rx] = v;
                    zf = (v == 8'd0);
                end
                bvm_pkg::OP_JMP: jump = 1'b1;
                bvm_pkg::OP_JZ:  jump = zf;
                bvm_pkg::OP_JNZ: jump = !zf;
                bvm_pkg::OP_JFE: jump = eof_f;
                bvm_pkg::OP_RET: halt_f = 1'b1;
                bvm_pkg::OP_ADD:
                begin
                    v = x + y;
                    regs[rx] = v;
                    zf = (v == 8'd0);
                end
                bvm_pkg::OP_SUB:
                begin
                    // saturates at zero
                    if (x <= y)
                    begin
                        zf = 1'b1;
                        regs[rx] = 8'd0;
                    end
                    else
                    begin
                        zf = 1'b0;
                        regs[rx] = x - y;
                    end
                end
                bvm_pkg::OP_XOR:
                begin
                    v = x ^ y;
                    regs[rx] = v;
                    zf = (v == 8'd0);
                end
                bvm_pkg::OP_OR:
                begin
                    v = x | y;
                    regs[rx] = v;
                    zf = (v == 8'd0);
                end
                bvm_pkg::OP_IN:
                begin
                    // at end of input Rx gets the last byte taken
                    if (r.in_eof)
                    begin
                        eof_f = 1'b1;
                    end
                    else
                    begin
                        eof_f = 1'b0;
                        last_in = r.data;
                        res.in_taken = 1'b1;
                    end
                    regs[rx] = last_in;
                    zf = 1'b0;
                end
                bvm_pkg::OP_OUT:
                begin
                    res.out_valid = 1'b1;
                    res.out_byte = x;
                    zf = 1'b0;
                end
                default: ;
            endcase
            if (op != bvm_pkg::OP_RET)
                pc_q = jump ? pc_q + opd : pc_q + 8'd2;
        end
        res.halted       = halt_f;
        res.prog_counter = pc_q;
        return res;
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected 0x%02h, got 0x%02h", name, want, got);
            fail_count++;
        end
    endfunction

    // Responses are matched before new requests are predicted, so a response
    // in the same cycle as an acceptance pairs with an older request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PROG_DEPTH; i++)
                prog_mem[i] = 8'd0;
            for (int i = 0; i < REG_COUNT; i++)
                regs[i] = 8'd0;
            pc_q    = 8'd0;
            zf      = 1'b0;
            eof_f   = 1'b0;
            halt_f  = 1'b0;
            last_in = 8'd0;
            expected_rsp_q.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_rsp_q.size() == 0)
                begin
                    $error("response 0x%h with no request outstanding", rsp);
                    fail_count++;
                end
                else
                begin
                    oldest = expected_rsp_q.pop_front();
                    check_field("out_valid", 8'(oldest.out_valid), 8'(rsp.out_valid));
                    check_field("out_byte", oldest.out_byte, rsp.out_byte);
                    check_field("in_taken", 8'(oldest.in_taken), 8'(rsp.in_taken));
                    check_field("halted", 8'(oldest.halted), 8'(rsp.halted));
                    check_field("prog_counter", oldest.prog_counter, rsp.prog_counter);
                end
            end
            if (req_valid && !req_stall)
                expected_rsp_q.push_back(execute_request(req));
            pending = expected_rsp_q.size();
        end
    end

endmodule

`default_nettype wire

[tb/sv/tb_byte_register_vm_core_unit.sv]
// Testbench top for byte_register_vm_core_unit: clock, reset, request and
// response stall stimulus, and the final verdict. Depends on bvm_pkg, the
// core and bvm_core_checker.
`default_nettype none

module tb_byte_register_vm_core_unit;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              req_valid = 1'b0;
    logic              req_stall;
    bvm_pkg::bvm_req_t req       = '0;
    logic              rsp_valid;
    logic              rsp_stall = 1'b0;
    bvm_pkg::bvm_rsp_t rsp;

    int         fail_count;
    int         pending;
    logic [7:0] predicted_pc;

    // Idle rates in percent, set per phase
    int         send_idle_pct  = 0;
    int         recv_stall_pct = 0;

    // Long response hold-off: asked by the stimulus, counted by the receiver
    int         holds_asked = 0;
    int         holds_done  = 0;
    int         hold_left   = 0;

    // Opening program at address 2: IN R1, INC R1, DEC R2, LSL R2,
    // SUB R1,R2 (saturates), JZ -10 (wraps past 255 back to 2)
    logic [7:0] demo_prog [12] = '{bvm_pkg::OP_IN, 8'h01, bvm_pkg::OP_INC, 8'h01,
                                   bvm_pkg::OP_DEC, 8'h02, bvm_pkg::OP_LSL, 8'h02,
                                   bvm_pkg::OP_SUB, 8'h21, bvm_pkg::OP_JZ, 8'hF6};

    byte_register_vm_core_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    bvm_core_checker u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req        (req),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp        (rsp),
        .fail_count (fail_count),
        .pending    (pending),
        .model_pc   (predicted_pc)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Response side stall
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            rsp_stall <= 1'b1;
            hold_left--;
        end
        else if (holds_done != holds_asked)
        begin
            holds_done++;
            hold_left = 80;
            rsp_stall <= 1'b1;
        end
        else
        begin
            rsp_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    initial
    begin
        #400000;
        $display("Test completed with failures");
        $finish;
    end

    // Offer one request; entered and left at a falling edge
    task automatic send_request(input bvm_pkg::bvm_req_t r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        do
            @(posedge clk);
        while (req_stall);
        @(negedge clk);
    endtask

    task automatic load_byte(input logic [7:0] a, input logic [7:0] d);
        bvm_pkg::bvm_req_t r;
        r.mode   = bvm_pkg::MODE_LOAD;
        r.addr   = a;
        r.data   = d;
        r.in_eof = 1'($urandom_range(1));
        send_request(r);
    endtask

    task automatic run_step(input logic [7:0] d, input logic eof);
        bvm_pkg::bvm_req_t r;
        r.mode   = bvm_pkg::MODE_RUN;
        r.addr   = 8'($urandom);
        r.data   = d;
        r.in_eof = eof;
        send_request(r);
    endtask

    // Instruction pairs, mostly at or just ahead of the predicted pc and some
    // scattered, stray bytes, and executed steps, which are the most common.
    // RET is never loaded here so the machine keeps running.
    task automatic random_phase(input int n_items);
        int         count;
        int         sel;
        logic [7:0] op;
        logic [7:0] opd;
        logic [7:0] base;
        logic [7:0] stray;
        count = 0;
        while (count < n_items)
        begin
            sel = $urandom_range(99);
            if (sel < 30)
            begin
                op = 8'($urandom_range(1, 16));
                if (op == bvm_pkg::OP_RET)
                    op = bvm_pkg::OP_OUT;
                if ($urandom_range(19) == 0)
                    op = $urandom_range(1) ? 8'd0 : 8'($urandom_range(18, 255));
                opd = 8'($urandom);
                // jumps use even offsets so the pc stays on instruction pairs
                if (op == bvm_pkg::OP_JMP || op == bvm_pkg::OP_JZ ||
                    op == bvm_pkg::OP_JNZ || op == bvm_pkg::OP_JFE)
                begin
                    opd = 8'($urandom_range(0, 12) * 2);
                    if ($urandom_range(1))
                        opd = 8'd0 - opd;
                end
                if (opd == bvm_pkg::OP_RET)
                    opd = opd ^ 8'h80;
                if ($urandom_range(2) != 0)
                    base = predicted_pc + 8'($urandom_range(0, 3) * 2);
                else
                    base = {7'($urandom), 1'b0};
                load_byte(base, op);
                load_byte(base + 8'd1, opd);
                count += 2;
            end
            else if (sel < 36)
            begin
                stray = 8'($urandom);
                if (stray == bvm_pkg::OP_RET)
                    stray = stray ^ 8'h80;
                load_byte(8'($urandom), stray);
                count++;
            end
            else
            begin
                run_step(8'($urandom), ($urandom_range(4) == 0));
                count++;
            end
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        send_idle_pct  = 25;
        recv_stall_pct = 46;

        // Empty store executes opcode 0, then the opening program runs once
        // and loops back, the second IN hitting end of input
        run_step(8'hA5, 1'b0);
        for (int i = 0; i < 12; i++)
            load_byte(8'(i + 2), demo_prog[i]);
        run_step(8'hFF, 1'b0);
        repeat (5) run_step(8'h00, 1'b0);
        run_step(8'h00, 1'b1);
        load_byte(8'hFF, 8'hFF);
        load_byte(8'h00, 8'h00);

        random_phase(160);

        send_idle_pct  = 46;
        recv_stall_pct = 25;
        random_phase(160);

        // No idling; the receiver holds off long enough to back up requests
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        holds_asked    = 1;
        random_phase(160);

        // Halt: RET at the current pc, then steps and a load while halted
        load_byte(predicted_pc, bvm_pkg::OP_RET);
        run_step(8'h3C, 1'b0);
        run_step(8'hC3, 1'b0);
        load_byte(8'($urandom), 8'($urandom));
        run_step(8'h5A, 1'b1);
        req_valid <= 1'b0;

        while (pending != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire
